FILE: hdl/wsd_pkg.sv
// types, constants and register map shared by the websocket frame deframer
// no dependencies
`timescale 1ns / 1ps

package wsd_pkg;

	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 64;
	localparam int LEN_W      = 63;

	typedef enum logic [2:0] {
		PH_B0,
		PH_B1,
		PH_EXT16,
		PH_EXT64,
		PH_KEY,
		PH_PAY
	} phase_t;

	// result kinds
	localparam logic [1:0] KIND_HDR = 2'd0;
	localparam logic [1:0] KIND_PAY = 2'd1;
	localparam logic [1:0] KIND_ERR = 2'd2;

	// error codes
	localparam logic ERR_PROTO = 1'b0;
	localparam logic ERR_BIG   = 1'b1;

	// opcodes
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PONG   = 4'hA;

	// register indexes (byte address is 8 * index)
	localparam logic [1:0] REG_SERVER_ROLE    = 2'd0;
	localparam logic [1:0] REG_COMPRESSION_ON = 2'd1;
	localparam logic [1:0] REG_FRAME_LIMIT    = 2'd2;

	localparam logic [6:0]       LEN7_EXT16     = 7'd126;
	localparam logic [6:0]       LEN7_EXT64     = 7'd127;
	localparam logic [63:0]      MIN_EXT16      = 64'd126;
	localparam logic [63:0]      MIN_EXT64      = 64'd65536;
	localparam logic [63:0]      CTRL_MAX_LEN   = 64'd125;
	localparam logic [LEN_W-1:0] SIZE_LIMIT_RST = 63'd1048576;

	typedef struct packed {
		logic             server_role;
		logic             compression_on;
		logic [LEN_W-1:0] frame_size_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       data;
		logic             fin;
		logic             rsv1;
		logic [3:0]       opcode;
		logic [LEN_W-1:0] length;
		logic             last;
		logic             error;
	} res_t;

	typedef struct packed {
		logic has_res;
		res_t res;
	} step_t;

endpackage

FILE: hdl/wsd_if.sv
// stream channel interfaces of the deframer: raw byte input and result output
// no dependencies
`timescale 1ns / 1ps

interface wsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface wsd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  out_kind;
	logic [7:0]  out_byte;
	logic        out_fin;
	logic        out_rsv1;
	logic [3:0]  out_opcode;
	logic [62:0] out_length;
	logic        out_last;
	logic        out_error;

	modport source (output valid, output out_kind, output out_byte, output out_fin,
		output out_rsv1, output out_opcode, output out_length, output out_last,
		output out_error, input ready);
	modport sink (input valid, input out_kind, input out_byte, input out_fin,
		input out_rsv1, input out_opcode, input out_length, input out_last,
		input out_error, output ready);
endinterface

FILE: hdl/websocket_frame_deframer.sv
// websocket frame deframer: one raw byte per beat in, header, payload or error beats out
// a byte accepted passes through the input register, then the result register;
// throughput one byte per cycle unless the output stalls, set by the single-byte parse step
// arst_n clears the parser to expect a first header byte and loads register reset values
// depends on wsd_pkg, wsd_if, wsd_regs, wsd_parse
`timescale 1ns / 1ps

module websocket_frame_deframer (
	input  logic                           clk,
	input  logic                           arst_n,
	wsd_in_if.sink                         in_ch,
	wsd_out_if.source                      out_ch,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [wsd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [wsd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [wsd_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);
	import wsd_pkg::*;

	cfg_t       cfg;
	step_t      step_res;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	res_t       res_s2;
	logic       adv;
	logic       in_acc;

	wsd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// result register free or being emptied this cycle
	assign adv         = !valid_s2 || out_ch.ready;
	assign in_ch.ready = !valid_s1 || adv;
	assign in_acc      = in_ch.valid && in_ch.ready;

	wsd_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (valid_s1 && adv),
		.in_byte (byte_s1),
		.cfg     (cfg),
		.res     (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= valid_s1 && step_res.has_res;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= in_ch.in_byte;
		end
		if (adv) begin
			res_s2 <= step_res.res;
		end
	end

	assign out_ch.valid      = valid_s2;
	assign out_ch.out_kind   = res_s2.kind;
	assign out_ch.out_byte   = res_s2.data;
	assign out_ch.out_fin    = res_s2.fin;
	assign out_ch.out_rsv1   = res_s2.rsv1;
	assign out_ch.out_opcode = res_s2.opcode;
	assign out_ch.out_length = res_s2.length;
	assign out_ch.out_last   = res_s2.last;
	assign out_ch.out_error  = res_s2.error;

	// nothing follows an error beat
	a_err_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.ready && out_ch.out_kind == KIND_ERR |=> !out_ch.valid)
		else $error("result after error beat");

	// a full pipeline with a stalled output takes no byte
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !out_ch.ready |-> !in_ch.ready)
		else $error("byte taken while pipeline stalled");

	// payload beats never carry a length
	a_pay_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.out_kind == KIND_PAY |-> out_ch.out_length == '0)
		else $error("payload beat with nonzero length");

endmodule

FILE: hdl/wsd_regs.sv
// apb configuration registers: server role, compression enable, frame size limit
// depends on wsd_pkg
`timescale 1ns / 1ps

module wsd_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [wsd_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [wsd_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [wsd_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	output wsd_pkg::cfg_t                    cfg
);
	import wsd_pkg::*;

	logic             role_q;
	logic             comp_q;
	logic [LEN_W-1:0] limit_q;
	logic             wr_en;
	logic [1:0]       reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[4:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			role_q  <= 1'b1;
			comp_q  <= 1'b0;
			limit_q <= SIZE_LIMIT_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SERVER_ROLE:    role_q  <= pwdata[0];
				REG_COMPRESSION_ON: comp_q  <= pwdata[0];
				REG_FRAME_LIMIT:    limit_q <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SERVER_ROLE:    prdata = {63'b0, role_q};
			REG_COMPRESSION_ON: prdata = {63'b0, comp_q};
			REG_FRAME_LIMIT:    prdata = {1'b0, limit_q};
			default:            prdata = '0;
		endcase
	end

	assign cfg.server_role      = role_q;
	assign cfg.compression_on   = comp_q;
	assign cfg.frame_size_limit = limit_q;

endmodule

FILE: hdl/wsd_parse.sv
// frame header walker and payload unmasker: state registers plus one byte of logic
// depends on wsd_pkg
`timescale 1ns / 1ps

module wsd_parse (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    in_byte,
	input  wsd_pkg::cfg_t cfg,
	output wsd_pkg::step_t res
);
	import wsd_pkg::*;

	phase_t           phase_q, phase_n;
	logic [7:0]       fbf_q, fbf_n;
	logic             masked_q, masked_n;
	logic [63:0]      len_q, len_n;
	logic [3:0]       left_q, left_n;
	logic [31:0]      key_q, key_n;
	logic [LEN_W-1:0] pl_q, pl_n;
	logic [1:0]       kidx_q, kidx_n;
	logic             err_q, err_n;

	logic [3:0]       op;
	logic             fin, rsv1;
	logic [6:0]       len7;
	logic             mask_bit, op_ok, b1_err;
	logic             in_b1, in_ext, in_key, in_pay;
	logic [63:0]      ext_len;
	logic [3:0]       ext_left_n;
	logic             ext_done, ext_bad;
	logic [63:0]      hdr_len;
	logic             too_big, ctrl_bad, masked_now;
	logic             reach_len, reach_hdr, to_key, fail;
	logic [LEN_W-1:0] pay_left_n;
	logic             pay_last;
	logic [7:0]       key_byte;

	assign op       = fbf_q[3:0];
	assign fin      = fbf_q[7];
	assign rsv1     = fbf_q[6];
	assign len7     = in_byte[6:0];
	assign mask_bit = in_byte[7];

	assign in_b1  = !err_q && (phase_q == PH_B1);
	assign in_ext = !err_q && (phase_q == PH_EXT16 || phase_q == PH_EXT64);
	assign in_key = !err_q && (phase_q == PH_KEY);
	assign in_pay = !err_q && (phase_q == PH_PAY);

	assign op_ok  = (op <= OP_BINARY) || (op >= OP_CLOSE && op <= OP_PONG);
	assign b1_err = !op_ok || (mask_bit != cfg.server_role) || (fbf_q[5:4] != 2'b00)
		|| (rsv1 && !cfg.compression_on) || (rsv1 && op != OP_TEXT && op != OP_BINARY);

	// big-endian extended length, one byte a beat
	assign ext_len    = {len_q[55:0], in_byte};
	assign ext_left_n = left_q - {3'b0, left_q != 4'd0};
	assign ext_done   = (ext_left_n == 4'd0);
	assign ext_bad    = (phase_q == PH_EXT16) ? (ext_len < MIN_EXT16)
		: ((ext_len < MIN_EXT64) || ext_len[63]);

	always_comb begin
		unique case (phase_q)
			PH_B1:              hdr_len = {57'b0, len7};
			PH_EXT16, PH_EXT64: hdr_len = ext_len;
			default:            hdr_len = len_q;
		endcase
	end

	assign too_big    = hdr_len > {1'b0, cfg.frame_size_limit};
	assign ctrl_bad   = op[3] && (!fin || hdr_len > CTRL_MAX_LEN);
	assign masked_now = (phase_q == PH_B1) ? mask_bit : masked_q;

	assign reach_len = (in_b1 && !b1_err && len7 < LEN7_EXT16)
		|| (in_ext && ext_done && !ext_bad);
	assign to_key    = reach_len && masked_now;
	assign reach_hdr = (reach_len && !masked_now) || (in_key && kidx_q == 2'd3);
	assign fail      = (in_b1 && b1_err) || (in_ext && ext_done && ext_bad)
		|| (reach_hdr && (too_big || ctrl_bad));

	assign pay_left_n = pl_q - {62'b0, pl_q != '0};
	assign pay_last   = (pay_left_n == '0);

	always_comb begin
		unique case (kidx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	// next state
	always_comb begin
		phase_n  = phase_q;
		fbf_n    = fbf_q;
		masked_n = masked_q;
		len_n    = len_q;
		left_n   = left_q;
		key_n    = key_q;
		pl_n     = pl_q;
		kidx_n   = kidx_q;
		err_n    = err_q;
		if (!err_q) begin
			unique case (phase_q)
				PH_B0: begin
					fbf_n   = in_byte;
					phase_n = PH_B1;
				end
				PH_B1: begin
					masked_n = mask_bit;
					key_n    = '0;
					len_n    = (len7 < LEN7_EXT16) ? {57'b0, len7} : 64'd0;
					if (len7 == LEN7_EXT16) begin
						phase_n = PH_EXT16;
						left_n  = 4'd2;
					end else if (len7 == LEN7_EXT64) begin
						phase_n = PH_EXT64;
						left_n  = 4'd8;
					end
				end
				PH_EXT16, PH_EXT64: begin
					len_n  = ext_len;
					left_n = ext_left_n;
				end
				PH_KEY: begin
					key_n  = {key_q[23:0], in_byte};
					kidx_n = kidx_q + 2'd1;
				end
				PH_PAY: begin
					kidx_n = kidx_q + 2'd1;
					pl_n   = pay_left_n;
					if (pay_last) begin
						phase_n = PH_B0;
					end
				end
				default: phase_n = PH_B0;
			endcase
			if (to_key) begin
				phase_n = PH_KEY;
				kidx_n  = 2'd0;
			end
			if (reach_hdr && !fail) begin
				pl_n    = hdr_len[LEN_W-1:0];
				kidx_n  = 2'd0;
				phase_n = (hdr_len == 64'd0) ? PH_B0 : PH_PAY;
			end
			if (fail) begin
				err_n = 1'b1;
			end
		end
	end

	// result of this beat
	always_comb begin
		res = '0;
		priority if (fail) begin
			res.has_res   = 1'b1;
			res.res.kind  = KIND_ERR;
			res.res.error = (reach_hdr && too_big) ? ERR_BIG : ERR_PROTO;
		end else if (reach_hdr) begin
			res.has_res    = 1'b1;
			res.res.kind   = KIND_HDR;
			res.res.fin    = fin;
			res.res.rsv1   = rsv1;
			res.res.opcode = op;
			res.res.length = hdr_len[LEN_W-1:0];
			res.res.last   = (hdr_len == 64'd0);
		end else if (in_pay) begin
			res.has_res    = 1'b1;
			res.res.kind   = KIND_PAY;
			res.res.data   = in_byte ^ key_byte;
			res.res.fin    = fin;
			res.res.rsv1   = rsv1;
			res.res.opcode = op;
			res.res.last   = pay_last;
		end else begin
			res.has_res = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_B0;
			fbf_q    <= '0;
			masked_q <= 1'b0;
			len_q    <= '0;
			left_q   <= '0;
			key_q    <= '0;
			pl_q     <= '0;
			kidx_q   <= '0;
			err_q    <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_n;
			fbf_q    <= fbf_n;
			masked_q <= masked_n;
			len_q    <= len_n;
			left_q   <= left_n;
			key_q    <= key_n;
			pl_q     <= pl_n;
			kidx_q   <= kidx_n;
			err_q    <= err_n;
		end
	end

endmodule
